// ===== sv/cramer_pkg.sv =====
// Package for the 2x2 Cramer solver: request and result payload types,
// the divider stage type and pipeline constants. No dependencies.
package cramer_pkg;

	localparam int unsigned QFrac  = 16;
	localparam int unsigned QBits  = 32;
	localparam int unsigned ProdW  = 64;
	localparam logic [QBits-1:0] QMaxPos = 32'h7FFF_FFFF;
	localparam logic [QBits-1:0] QMaxNeg = 32'h8000_0000;

	typedef struct packed {
		logic signed [31:0] a11;
		logic signed [31:0] a12;
		logic signed [31:0] a21;
		logic signed [31:0] a22;
		logic signed [31:0] rhs1;
		logic signed [31:0] rhs2;
	} req_t;

	typedef struct packed {
		logic signed [31:0] x1;
		logic signed [31:0] x2;
		logic               singular;
		logic               overflow;
	} res_t;

	// one unknown as it walks through the divider stages
	typedef struct packed {
		logic [ProdW-1:0] rem;
		logic [QBits-1:0] quo;
		logic [QBits-1:0] feed;
		logic             neg;
		logic             big;
	} div_t;

endpackage

// ===== sv/cramer_2x2_solver.sv =====
// Top level of the 2x2 Cramer solver: products, differences, magnitudes,
// a bit-per-stage restoring divider pair and saturation. Uses cramer_pkg.
//
// Usage:
//   Request channel in_valid/in_ready/in_data carries a11..a22, rhs1, rhs2
//   (signed Q16.16). Result channel out_valid/out_ready/out_data carries
//   x1, x2 (signed Q16.16, truncated toward zero, saturated), singular and
//   overflow.
//   Pipeline from request accept to result valid: three front stages,
//   one divider load stage, 32 divider stages, one output register.
//   Throughput: one request per cycle while the receiver does not stall;
//   the 32-stage divider pair produces one quotient bit per stage for
//   each unknown, so every stage holds a different request.
//   All stages advance together while the output register is empty or is
//   being taken; when the receiver stalls with a result waiting, the whole
//   pipe holds and in_ready drops, so nothing is lost or repeated.
//   Reset (arst_n low) clears all stage valid bits; payload is not reset.
//   A zero determinant gives x1 = x2 = 0, singular = 1, overflow = 0.
//   A quotient outside Q16.16 clamps to 0x7FFFFFFF or 0x80000000 and sets
//   overflow.
module cramer_2x2_solver (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cramer_pkg::req_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output cramer_pkg::res_t  out_data
);

	localparam int unsigned W  = cramer_pkg::ProdW;
	localparam int unsigned QB = cramer_pkg::QBits;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: six products, exact Q32.32
	logic signed [W-1:0] p1122_s1, p2112_s1, pr22_s1, p12r2_s1, p11r2_s1, pr121_s1;
	logic v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1122_s1 <= W'(in_data.a11) * W'(in_data.a22);
			p2112_s1 <= W'(in_data.a21) * W'(in_data.a12);
			pr22_s1  <= W'(in_data.rhs1) * W'(in_data.a22);
			p12r2_s1 <= W'(in_data.a12) * W'(in_data.rhs2);
			p11r2_s1 <= W'(in_data.a11) * W'(in_data.rhs2);
			pr121_s1 <= W'(in_data.rhs1) * W'(in_data.a21);
		end
	end

	// stage 2: determinant and numerators; cannot overflow 64 bits
	logic signed [W-1:0] det_s2, n1_s2, n2_s2;
	logic v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s2 <= p1122_s1 - p2112_s1;
			n1_s2  <= pr22_s1 - p12r2_s1;
			n2_s2  <= p11r2_s1 - pr121_s1;
		end
	end

	// stage 3: magnitudes, signs, singular
	logic [W-1:0] dm_s3, n1m_s3, n2m_s3;
	logic neg1_s3, neg2_s3, sing_s3, v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dm_s3   <= det_s2[W-1] ? W'(-det_s2) : W'(det_s2);
			n1m_s3  <= n1_s2[W-1] ? W'(-n1_s2) : W'(n1_s2);
			n2m_s3  <= n2_s2[W-1] ? W'(-n2_s2) : W'(n2_s2);
			neg1_s3 <= n1_s2[W-1] ^ det_s2[W-1];
			neg2_s3 <= n2_s2[W-1] ^ det_s2[W-1];
			sing_s3 <= (det_s2 == '0);
		end
	end

	// divider stages: index 0 is loaded from stage 3, index k+1 adds one
	// quotient bit. The top 48 dividend bits form the first remainder; if
	// they are not below the divisor the quotient needs more than 32 bits.
	cramer_pkg::div_t dv1_q [0:QB];
	cramer_pkg::div_t dv2_q [0:QB];
	logic [W-1:0]     dd_q  [0:QB];
	logic             ds_q  [0:QB];
	logic             dvv_q [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvv_q[0] <= 1'b0;
		end else if (en) begin
			dvv_q[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dd_q[0]       <= dm_s3;
			ds_q[0]       <= sing_s3;
			dv1_q[0].rem  <= W'(n1m_s3[W-1:cramer_pkg::QFrac]);
			dv1_q[0].quo  <= '0;
			dv1_q[0].feed <= {n1m_s3[cramer_pkg::QFrac-1:0], {cramer_pkg::QFrac{1'b0}}};
			dv1_q[0].neg  <= neg1_s3;
			dv1_q[0].big  <= (W'(n1m_s3[W-1:cramer_pkg::QFrac]) >= dm_s3);
			dv2_q[0].rem  <= W'(n2m_s3[W-1:cramer_pkg::QFrac]);
			dv2_q[0].quo  <= '0;
			dv2_q[0].feed <= {n2m_s3[cramer_pkg::QFrac-1:0], {cramer_pkg::QFrac{1'b0}}};
			dv2_q[0].neg  <= neg2_s3;
			dv2_q[0].big  <= (W'(n2m_s3[W-1:cramer_pkg::QFrac]) >= dm_s3);
		end
	end

	for (genvar g = 0; g < QB; g++) begin : g_div
		logic [W:0] sh1, sh2;
		logic       ge1, ge2;
		logic [W:0] nr1, nr2;

		always_comb begin
			sh1 = {dv1_q[g].rem, dv1_q[g].feed[QB-1]};
			sh2 = {dv2_q[g].rem, dv2_q[g].feed[QB-1]};
			ge1 = sh1 >= {1'b0, dd_q[g]};
			ge2 = sh2 >= {1'b0, dd_q[g]};
			nr1 = ge1 ? sh1 - {1'b0, dd_q[g]} : sh1;
			nr2 = ge2 ? sh2 - {1'b0, dd_q[g]} : sh2;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_q[g+1] <= 1'b0;
			end else if (en) begin
				dvv_q[g+1] <= dvv_q[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dd_q[g+1]       <= dd_q[g];
				ds_q[g+1]       <= ds_q[g];
				dv1_q[g+1].rem  <= nr1[W-1:0];
				dv1_q[g+1].quo  <= {dv1_q[g].quo[QB-2:0], ge1};
				dv1_q[g+1].feed <= {dv1_q[g].feed[QB-2:0], 1'b0};
				dv1_q[g+1].neg  <= dv1_q[g].neg;
				dv1_q[g+1].big  <= dv1_q[g].big;
				dv2_q[g+1].rem  <= nr2[W-1:0];
				dv2_q[g+1].quo  <= {dv2_q[g].quo[QB-2:0], ge2};
				dv2_q[g+1].feed <= {dv2_q[g].feed[QB-2:0], 1'b0};
				dv2_q[g+1].neg  <= dv2_q[g].neg;
				dv2_q[g+1].big  <= dv2_q[g].big;
			end
		end
	end

	// saturation and sign, then the output register
	logic [QB-1:0] x1_c, x2_c;
	logic          sat1_c, sat2_c;

	always_comb begin
		if (!dv1_q[QB].neg) begin
			sat1_c = dv1_q[QB].big || (dv1_q[QB].quo > cramer_pkg::QMaxPos);
			x1_c   = sat1_c ? cramer_pkg::QMaxPos : dv1_q[QB].quo;
		end else begin
			sat1_c = dv1_q[QB].big || (dv1_q[QB].quo > cramer_pkg::QMaxNeg);
			x1_c   = sat1_c ? cramer_pkg::QMaxNeg : QB'(-dv1_q[QB].quo);
		end
		if (!dv2_q[QB].neg) begin
			sat2_c = dv2_q[QB].big || (dv2_q[QB].quo > cramer_pkg::QMaxPos);
			x2_c   = sat2_c ? cramer_pkg::QMaxPos : dv2_q[QB].quo;
		end else begin
			sat2_c = dv2_q[QB].big || (dv2_q[QB].quo > cramer_pkg::QMaxNeg);
			x2_c   = sat2_c ? cramer_pkg::QMaxNeg : QB'(-dv2_q[QB].quo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dvv_q[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ds_q[QB]) begin
				out_data.x1       <= '0;
				out_data.x2       <= '0;
				out_data.singular <= 1'b1;
				out_data.overflow <= 1'b0;
			end else begin
				out_data.x1       <= x1_c;
				out_data.x2       <= x2_c;
				out_data.singular <= 1'b0;
				out_data.overflow <= sat1_c || sat2_c;
			end
		end
	end

	// a singular result never carries values or an overflow
	a_sing_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.singular |->
			out_data.x1 == '0 && out_data.x2 == '0 && !out_data.overflow)
		else $error("singular result with nonzero payload");

	// a stalled result holds while the pipe is frozen
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	// an accepted request always lands in stage 1
	a_front_adv: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted request lost in stage 1");

endmodule
